[sv/pfdr_pkg.sv]
// ----------------------------------------------------------------------------
// Paged framebuffer package
// Shared types, codes and defaults for the paged framebuffer draw and refresh
// block.
// ----------------------------------------------------------------------------
package pfdr_pkg;

  localparam int COLUMNS_DEF = 128;
  localparam int PAGES_DEF   = 8;

  localparam int PAGE_IDX_W  = 4;
  localparam int WORD_IDX_W  = 5;
  localparam int QUEUE_DEPTH = 2;

  localparam logic KIND_CMD  = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_LOW   = 8'h00;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

  typedef enum logic [1:0] {
    OP_DRAW    = 2'd0,
    OP_FILL    = 2'd1,
    OP_REFRESH = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic {
    JOB_FILL,
    JOB_REFRESH
  } job_kind_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL_RD,
    ST_FILL_WR,
    ST_CMD_PAGE,
    ST_CMD_LOW,
    ST_CMD_HIGH,
    ST_DATA
  } back_state_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] x_start;
    logic [7:0] y_start;
    logic [7:0] x_end;
    logic [7:0] y_end;
    logic       pixel_on;
    logic [2:0] page;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  command_byte;
    logic [63:0] data_word;
    logic        last;
  } out_item_t;

  typedef struct packed {
    job_kind_e               kind;
    logic                    pixel_on;
    logic [7:0]              x_lo;
    logic [7:0]              x_hi;
    logic [7:0]              y_lo;
    logic [7:0]              y_hi;
    logic [PAGE_IDX_W-1:0]   page_lo;
    logic [PAGE_IDX_W-1:0]   page_hi;
    logic [WORD_IDX_W-1:0]   word_lo;
    logic [WORD_IDX_W-1:0]   word_hi;
    logic [2:0]              page;
  } job_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

[sv/pfdr_front.sv]
// ----------------------------------------------------------------------------
// Paged framebuffer front end
// Accepts items, clips fill coordinates to the screen, drops items
// that touch nothing and turns the rest into jobs for the queue.
// ----------------------------------------------------------------------------
module pfdr_front #(
  parameter int COLUMNS = pfdr_pkg::COLUMNS_DEF,
  parameter int PAGES   = pfdr_pkg::PAGES_DEF
) (
  input  logic                 start,
  input  pfdr_pkg::in_item_t   item_i,
  input  pfdr_pkg::back_status_t status_i,
  input  logic                 queue_full_i,
  output logic                 busy,
  output logic                 push_o,
  output pfdr_pkg::job_t       job_o
);

  localparam int         ROWS     = PAGES * 8;
  localparam logic [8:0] COL_LIM  = 9'(COLUMNS);
  localparam logic [8:0] ROW_LIM  = 9'(ROWS);
  localparam logic [7:0] COL_MAX  = 8'(COLUMNS - 1);
  localparam logic [7:0] ROW_MAX  = 8'(ROWS - 1);
  localparam logic [4:0] PAGE_TOP = 5'(PAGES - 1);

  logic keep;
  logic accept;

  assign busy   = status_i.clearing || queue_full_i;
  assign accept = start && !busy;
  assign push_o = accept && keep;

  always_comb begin
    keep           = 1'b0;
    job_o          = '0;
    job_o.kind     = pfdr_pkg::JOB_FILL;
    job_o.pixel_on = item_i.pixel_on;
    job_o.page     = item_i.page;
    case (pfdr_pkg::op_e'(item_i.operation))
      pfdr_pkg::OP_DRAW: begin
        keep       = ({1'b0, item_i.x_start} < COL_LIM) && ({1'b0, item_i.y_start} < ROW_LIM);
        job_o.x_lo = item_i.x_start;
        job_o.x_hi = item_i.x_start;
        job_o.y_lo = item_i.y_start;
        job_o.y_hi = item_i.y_start;
      end
      pfdr_pkg::OP_FILL: begin
        keep       = (item_i.x_start <= item_i.x_end) && (item_i.y_start <= item_i.y_end) &&
                     ({1'b0, item_i.x_start} < COL_LIM) && ({1'b0, item_i.y_start} < ROW_LIM);
        job_o.x_lo = item_i.x_start;
        job_o.x_hi = (item_i.x_end > COL_MAX) ? COL_MAX : item_i.x_end;
        job_o.y_lo = item_i.y_start;
        job_o.y_hi = (item_i.y_end > ROW_MAX) ? ROW_MAX : item_i.y_end;
      end
      pfdr_pkg::OP_REFRESH: begin
        keep       = 1'b1;
        job_o.kind = pfdr_pkg::JOB_REFRESH;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
    // Larger row numbers live in lower-numbered pages, so the bottom row sets the first page.
    job_o.page_lo = pfdr_pkg::PAGE_IDX_W'(PAGE_TOP - job_o.y_hi[7:3]);
    job_o.page_hi = pfdr_pkg::PAGE_IDX_W'(PAGE_TOP - job_o.y_lo[7:3]);
    job_o.word_lo = job_o.x_lo[7:3];
    job_o.word_hi = job_o.x_hi[7:3];
  end

endmodule

[sv/pfdr_queue.sv]
// ----------------------------------------------------------------------------
// Paged framebuffer job queue
// Short first-in first-out queue of jobs between the front end and the
// back end.
// ----------------------------------------------------------------------------
module pfdr_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pfdr_pkg::job_t job_i,
  input  logic           pop_i,
  output pfdr_pkg::job_t job_o,
  output logic           full_o,
  output logic           empty_o
);

  localparam int PTR_W = (pfdr_pkg::QUEUE_DEPTH > 1) ? $clog2(pfdr_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(pfdr_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(pfdr_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(pfdr_pkg::QUEUE_DEPTH);

  pfdr_pkg::job_t   entries_q [pfdr_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == CNT_FULL);
  assign empty_o = (count_q == '0);
  assign job_o   = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

[sv/pfdr_back.sv]
// ----------------------------------------------------------------------------
// Paged framebuffer back end
// Owns the page memory: clears it after reset, applies fill jobs one word at
// a time by read-modify-write and streams refresh pages to the result port.
// ----------------------------------------------------------------------------
module pfdr_back #(
  parameter int COLUMNS = pfdr_pkg::COLUMNS_DEF,
  parameter int PAGES   = pfdr_pkg::PAGES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pfdr_pkg::job_t         job_i,
  input  logic                   empty_i,
  output logic                   pop_o,
  output pfdr_pkg::back_status_t status_o,
  output logic                   strobe,
  output pfdr_pkg::out_item_t    result_o
);

  localparam int WPP   = (COLUMNS + 7) / 8;
  localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int WW    = (WPP > 1) ? $clog2(WPP) : 1;
  localparam int AW    = PW + WW;
  localparam int DEPTH = 1 << AW;
  localparam logic [4:0]    PAGE_TOP  = 5'(PAGES - 1);
  localparam logic [4:0]    PAGE_LIM  = 5'(PAGES);
  localparam logic [WW-1:0] WORD_LAST = WW'(WPP - 1);
  localparam logic [AW-1:0] ADDR_LAST = AW'(DEPTH - 1);

  pfdr_pkg::back_state_e state_q, state_d;
  pfdr_pkg::job_t        cur_q, cur_d;
  logic [PW-1:0]         page_q, page_d;
  logic [WW-1:0]         word_q, word_d;
  logic [AW-1:0]         clr_q, clr_d;
  logic                  strobe_q, strobe_d;
  pfdr_pkg::out_item_t   result_q, result_d;

  logic [63:0] mem [DEPTH];
  logic [63:0] rd_data_q;
  logic        rd_en;
  logic [AW-1:0] rd_addr;
  logic        wr_en;
  logic [AW-1:0] wr_addr;
  logic [63:0] wr_data;

  logic [63:0]   fill_mask;
  logic          fill_done;
  logic          page_ok;
  logic [PW-1:0] ref_page;
  logic [4:0]    row_grp;
  logic [8:0]    col;
  logic [7:0]    row;
  logic          col_in;

  assign status_o.clearing = (state_q == pfdr_pkg::ST_CLEAR);
  assign strobe            = strobe_q;
  assign result_o          = result_q;
  assign fill_done         = (word_q == WW'(cur_q.word_hi)) && (page_q == PW'(cur_q.page_hi));
  assign page_ok           = ({2'b00, cur_q.page} < PAGE_LIM);
  assign ref_page          = PW'(cur_q.page);

  always_comb begin
    row_grp   = PAGE_TOP - 5'(page_q);
    fill_mask = '0;
    col       = '0;
    row       = '0;
    col_in    = 1'b0;
    for (int b = 0; b < 8; b++) begin
      col    = 9'({word_q, 3'(b)});
      col_in = (col >= {1'b0, cur_q.x_lo}) && (col <= {1'b0, cur_q.x_hi});
      for (int r = 0; r < 8; r++) begin
        row = {row_grp, 3'(r)};
        fill_mask[b * 8 + 7 - r] = col_in && (row >= cur_q.y_lo) && (row <= cur_q.y_hi);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      pfdr_pkg::ST_CLEAR: begin
        if (clr_q == ADDR_LAST) begin
          state_d = pfdr_pkg::ST_IDLE;
        end
      end
      pfdr_pkg::ST_IDLE: begin
        if (!empty_i) begin
          state_d = (job_i.kind == pfdr_pkg::JOB_FILL) ? pfdr_pkg::ST_FILL_RD
                                                       : pfdr_pkg::ST_CMD_PAGE;
        end
      end
      pfdr_pkg::ST_FILL_RD:  state_d = pfdr_pkg::ST_FILL_WR;
      pfdr_pkg::ST_FILL_WR: begin
        state_d = fill_done ? pfdr_pkg::ST_IDLE : pfdr_pkg::ST_FILL_RD;
      end
      pfdr_pkg::ST_CMD_PAGE: state_d = pfdr_pkg::ST_CMD_LOW;
      pfdr_pkg::ST_CMD_LOW:  state_d = pfdr_pkg::ST_CMD_HIGH;
      pfdr_pkg::ST_CMD_HIGH: state_d = pfdr_pkg::ST_DATA;
      pfdr_pkg::ST_DATA: begin
        if (word_q == WORD_LAST) begin
          state_d = pfdr_pkg::ST_IDLE;
        end
      end
      default: state_d = pfdr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cur_d    = cur_q;
    page_d   = page_q;
    word_d   = word_q;
    clr_d    = clr_q;
    pop_o    = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = {page_q, word_q};
    wr_en    = 1'b0;
    wr_addr  = {page_q, word_q};
    wr_data  = '0;
    strobe_d = 1'b0;
    result_d = '0;
    case (state_q)
      pfdr_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        clr_d   = clr_q + 1'b1;
      end
      pfdr_pkg::ST_IDLE: begin
        if (!empty_i) begin
          pop_o  = 1'b1;
          cur_d  = job_i;
          page_d = PW'(job_i.page_lo);
          word_d = WW'(job_i.word_lo);
        end
      end
      pfdr_pkg::ST_FILL_RD: begin
        rd_en = 1'b1;
      end
      pfdr_pkg::ST_FILL_WR: begin
        wr_en   = 1'b1;
        wr_data = cur_q.pixel_on ? (rd_data_q | fill_mask) : (rd_data_q & ~fill_mask);
        if (word_q == WW'(cur_q.word_hi)) begin
          word_d = WW'(cur_q.word_lo);
          page_d = page_q + 1'b1;
        end else begin
          word_d = word_q + 1'b1;
        end
      end
      pfdr_pkg::ST_CMD_PAGE: begin
        strobe_d              = 1'b1;
        result_d.kind         = pfdr_pkg::KIND_CMD;
        result_d.command_byte = pfdr_pkg::CMD_PAGE_BASE + {5'b00000, cur_q.page};
      end
      pfdr_pkg::ST_CMD_LOW: begin
        strobe_d              = 1'b1;
        result_d.kind         = pfdr_pkg::KIND_CMD;
        result_d.command_byte = pfdr_pkg::CMD_COL_LOW;
      end
      pfdr_pkg::ST_CMD_HIGH: begin
        strobe_d              = 1'b1;
        result_d.kind         = pfdr_pkg::KIND_CMD;
        result_d.command_byte = pfdr_pkg::CMD_COL_HIGH;
        rd_en                 = 1'b1;
        rd_addr               = {ref_page, {WW{1'b0}}};
        word_d                = '0;
      end
      pfdr_pkg::ST_DATA: begin
        strobe_d           = 1'b1;
        result_d.kind      = pfdr_pkg::KIND_DATA;
        result_d.data_word = page_ok ? rd_data_q : '0;
        result_d.last      = (word_q == WORD_LAST);
        if (word_q != WORD_LAST) begin
          rd_en   = 1'b1;
          rd_addr = {ref_page, word_q + 1'b1};
          word_d  = word_q + 1'b1;
        end
      end
      default: begin
        strobe_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pfdr_pkg::ST_CLEAR;
      clr_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    page_q   <= page_d;
    word_q   <= word_d;
    result_q <= result_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

endmodule

[sv/paged_framebuffer_draw_refresh_top.sv]
// ----------------------------------------------------------------------------
// Paged framebuffer draw and refresh
// Monochrome page framebuffer with pixel draw, rectangle fill and page refresh.
// ----------------------------------------------------------------------------
// After reset the page memory is cleared one word per cycle while busy is high;
// the screen then reads dark. A refresh gives three command results and one
// data result per eight columns in consecutive cycles. A draw or fill reads
// each page memory word it touches and then writes it back, one word after
// another. A two-entry job queue lets the next items be accepted while the
// current one runs.
module paged_framebuffer_draw_refresh_top #(
  parameter int COLUMNS = pfdr_pkg::COLUMNS_DEF,
  parameter int PAGES   = pfdr_pkg::PAGES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  pfdr_pkg::in_item_t  item_i,
  output logic                busy,
  output logic                strobe,
  output pfdr_pkg::out_item_t result_o
);

  pfdr_pkg::back_status_t status;
  pfdr_pkg::job_t         push_job;
  pfdr_pkg::job_t         head_job;
  logic                   push;
  logic                   pop;
  logic                   queue_full;
  logic                   queue_empty;

  pfdr_front #(
    .COLUMNS(COLUMNS),
    .PAGES  (PAGES)
  ) u_front (
    .start       (start),
    .item_i      (item_i),
    .status_i    (status),
    .queue_full_i(queue_full),
    .busy        (busy),
    .push_o      (push),
    .job_o       (push_job)
  );

  pfdr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .job_o  (head_job),
    .full_o (queue_full),
    .empty_o(queue_empty)
  );

  pfdr_back #(
    .COLUMNS(COLUMNS),
    .PAGES  (PAGES)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .job_i   (head_job),
    .empty_i (queue_empty),
    .pop_o   (pop),
    .status_o(status),
    .strobe  (strobe),
    .result_o(result_o)
  );

endmodule

[sv/pfdr_checker.sv]
// ----------------------------------------------------------------------------
// Paged framebuffer port checker
// Checks the order of a refresh transfer run as seen on the result port.
// ----------------------------------------------------------------------------
module pfdr_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                strobe,
  input pfdr_pkg::out_item_t result_o
);

  a_run_opens_with_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && !$past(strobe) |->
      result_o.kind == pfdr_pkg::KIND_CMD && result_o.command_byte[7:4] == 4'hB)
    else $error("A result run does not open with a page command.");

  a_page_then_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && result_o.kind == pfdr_pkg::KIND_CMD && result_o.command_byte[7:4] == 4'hB |=>
      strobe && result_o.kind == pfdr_pkg::KIND_CMD &&
      result_o.command_byte == pfdr_pkg::CMD_COL_LOW)
    else $error("The page command is not followed by the low column command.");

  a_high_then_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && result_o.kind == pfdr_pkg::KIND_CMD &&
    result_o.command_byte == pfdr_pkg::CMD_COL_HIGH |=>
      strobe && result_o.kind == pfdr_pkg::KIND_DATA)
    else $error("The high column command is not followed by data.");

  a_last_is_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && result_o.last |-> result_o.kind == pfdr_pkg::KIND_DATA)
    else $error("The last flag is set on a command transfer.");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && result_o.last |=> !strobe)
    else $error("A transfer follows the last data word directly.");

endmodule

bind paged_framebuffer_draw_refresh_top pfdr_checker u_pfdr_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .strobe  (strobe),
  .result_o(result_o)
);
